@@ rtl/feedback_comb_echo_macros.svh @@
// ----------------------------------------------------------------------------
// Feedback comb echo assertion macros
// Shared concurrent assertion forms for the echo block. Each use expands to
// one labeled property on clk with an error report.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_COMB_ECHO_MACROS_SVH
`define FEEDBACK_COMB_ECHO_MACROS_SVH

// Checked only while reset is released.
`define FCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define FCE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/fce_pkg.sv @@
// ----------------------------------------------------------------------------
// Feedback comb echo package
// Widths, register codes, reset values and shared helpers of the echo block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fce_pkg;

  // Delay line depth and the widths that follow from it.
  localparam int MAX_DELAY = 1024;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int CNT_W     = $clog2(MAX_DELAY + 1);

  // Fixed field widths.
  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 11;
  localparam int GAIN_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // Widest intermediate value that gets saturated (sample times gain).
  localparam int SAT_IN_W = SAMPLE_W + GAIN_W + 1;

  // Exact divide by three for magnitudes below 2^17: q = (m * 43691) >> 17.
  localparam int          MAG_W      = SAMPLE_W + 1;
  localparam int          DIV3_SHIFT = 17;
  localparam logic [16:0] DIV3_MUL   = 17'd43691;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 11'd560;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY = 1'b0,
    CFG_GAIN  = 1'b1
  } cfg_idx_e;

  // Write port of the delay line.
  typedef struct packed {
    logic                       en;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] data;
  } mem_wr_t;

  // Clamp to the 16-bit signed range.
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] r;
    hi = SAT_IN_W'(32767);
    lo = SAT_IN_W'(-32768);
    if (v > hi) begin
      r = 16'sh7fff;
    end else if (v < lo) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/fce_delay_mem.sv @@
// ----------------------------------------------------------------------------
// Echo delay line
// Circular sample store with one write and one registered read port. A read
// that hits the entry written in the same cycle returns the new value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fce_delay_mem
  import fce_pkg::*;
(
  input  logic                       clk,
  input  mem_wr_t                    wr,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [MAX_DELAY];
  logic signed [SAMPLE_W-1:0] ram_q_r;
  logic signed [SAMPLE_W-1:0] byp_data_r;
  logic                       byp_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ram_q_r    <= mem[rd_addr];
      byp_r      <= wr.en && (wr.addr == rd_addr);
      byp_data_r <= wr.data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : ram_q_r;

endmodule

@@ rtl/fce_echo_arith.sv @@
// ----------------------------------------------------------------------------
// Echo mixer
// When use_echo is set, adds two thirds of the delayed sample, truncated
// toward zero, to the incoming sample; the sum is saturated to 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fce_echo_arith
  import fce_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic signed [SAMPLE_W-1:0] past,
  input  logic                       use_echo,
  output logic signed [SAMPLE_W-1:0] y
);

  logic signed [MAG_W-1:0]            twice;
  logic                               neg;
  logic [MAG_W-1:0]                   mag;
  logic [MAG_W+DIV3_SHIFT-1:0]        prod;
  logic [MAG_W-1:0]                   quot;
  logic signed [MAG_W:0]              echo;
  logic signed [SAT_IN_W-1:0]         sum;

  always_comb begin
    twice = {past, 1'b0};
    neg   = twice[MAG_W-1];
    mag   = neg ? MAG_W'(-twice) : MAG_W'(twice);
    // Magnitude path keeps the truncation toward zero for negative values.
    prod  = (MAG_W+DIV3_SHIFT)'(mag) * (MAG_W+DIV3_SHIFT)'(DIV3_MUL);
    quot  = prod[MAG_W+DIV3_SHIFT-1:DIV3_SHIFT];
    echo  = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    if (!use_echo) begin
      echo = '0;
    end
    sum   = SAT_IN_W'(sample) + SAT_IN_W'(echo);
    y     = sat16(sum);
  end

endmodule

@@ rtl/fce_gain_stage.sv @@
// ----------------------------------------------------------------------------
// Playback gain stage
// Holds the echo sample for one stage, scales it by the playback gain with
// saturation, and keeps both results in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fce_gain_stage
  import fce_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       y_valid,
  output logic                       y_ready,
  input  logic signed [SAMPLE_W-1:0] y,
  input  logic [GAIN_W-1:0]          gain,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic                       s2_valid_r;
  logic signed [SAMPLE_W-1:0] s2_y_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] echo_r;
  logic signed [SAMPLE_W-1:0] played_r;
  logic                       out_free;
  logic signed [SAT_IN_W-1:0] scaled;

  assign out_free = !out_valid_r || out_tready;
  assign y_ready  = !s2_valid_r || out_free;

  assign scaled = SAT_IN_W'(s2_y_r) * SAT_IN_W'($signed({1'b0, gain}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (y_ready) begin
        s2_valid_r <= y_valid;
      end
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (y_ready && y_valid) begin
      s2_y_r <= y;
    end
    if (out_free && s2_valid_r) begin
      echo_r   <= s2_y_r;
      played_r <= sat16(scaled);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {played_r, echo_r};

endmodule

@@ rtl/feedback_comb_echo.sv @@
// ----------------------------------------------------------------------------
// Feedback comb echo
// Streaming echo: each sample is mixed with two thirds of the echo output
// from a programmable number of samples earlier, with a scaled playback copy.
// ----------------------------------------------------------------------------
// The block takes one 16-bit sample per clock while the output side does not
// stall and returns one result per sample, in order. An accepted input is
// registered together with its delay line read; the echo mix result is then
// registered in the gain stage, and the playback gain multiply feeds the
// output register. The single write port of the delay line takes one echo
// sample in each cycle in which the mix stage hands one on. The echo history
// holds up to 1024 samples and needs no clearing after reset: a fill count
// keeps unwritten history out of the mix. Setting in_tuser on a sample starts
// a new recording, so that sample and the following ones see no echo until
// the programmed delay has gone by again. Configuration is to be written only
// while no transaction is in flight.
`timescale 1ns / 1ps

module feedback_comb_echo
  import fce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] sample_in
  input  logic                  in_tuser,   // [0] restart
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] echo_sample, [31:16] played_sample
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "feedback_comb_echo_macros.svh"

  // Data carried from the input register into the mix stage.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       use_echo;
    logic [ADDR_W-1:0]          wp;
  } s1_t;

  logic [DELAY_W-1:0]         cfg_delay_r;
  logic [GAIN_W-1:0]          cfg_gain_r;

  logic [ADDR_W-1:0]          wp_r;
  logic [ADDR_W-1:0]          wp_nxt;
  logic [CNT_W-1:0]           fill_r;
  logic [CNT_W-1:0]           fill_nxt;
  logic [CNT_W-1:0]           fill_base;
  logic [CNT_W-1:0]           delay_eff;
  logic [31:0]                delay_ext;
  logic [CNT_W-1:0]           wp_ext;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       use_echo;

  logic                       s1_valid_r;
  s1_t                        s1_r;
  logic                       s2_ready;
  logic                       in_fire;
  logic signed [SAMPLE_W-1:0] past;
  logic signed [SAMPLE_W-1:0] y;
  mem_wr_t                    mem_wr;

  // Configuration registers; writes to an unknown index fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_delay_r <= DELAY_RESET;
      cfg_gain_r  <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_addr))
        CFG_DELAY: cfg_delay_r <= cfg_wdata[DELAY_W-1:0];
        CFG_GAIN:  cfg_gain_r  <= cfg_wdata[GAIN_W-1:0];
        default:   ;
      endcase
    end
  end

  // The input register only waits on the stage after it.
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_fire   = in_tvalid && in_tready;

  // A zero delay acts as one sample; anything past the line depth is clamped.
  always_comb begin
    delay_ext = 32'(cfg_delay_r);
    if (delay_ext == 32'd0) begin
      delay_ext = 32'd1;
    end else if (delay_ext > 32'(MAX_DELAY)) begin
      delay_ext = 32'(MAX_DELAY);
    end
    delay_eff = CNT_W'(delay_ext);
  end

  // History address, wrapped around the line without a modulo.
  always_comb begin
    wp_ext = CNT_W'(wp_r);
    if (wp_ext >= delay_eff) begin
      rd_addr = ADDR_W'(wp_ext - delay_eff);
    end else begin
      rd_addr = ADDR_W'(wp_ext + CNT_W'(MAX_DELAY) - delay_eff);
    end
  end

  // A restart drops the history before this sample decides on its echo.
  always_comb begin
    fill_base = in_tuser ? '0 : fill_r;
    use_echo  = fill_base >= delay_eff;
    fill_nxt  = (fill_base < CNT_W'(MAX_DELAY)) ? fill_base + CNT_W'(1) : fill_base;
    wp_nxt    = (wp_r == ADDR_W'(MAX_DELAY - 1)) ? '0 : wp_r + ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      fill_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.sample   <= $signed(in_tdata[SAMPLE_W-1:0]);
      s1_r.use_echo <= use_echo;
      s1_r.wp       <= wp_r;
    end
  end

  // The echo sample is stored as it leaves the mix stage; a read issued in
  // the same cycle picks it up through the bypass in the memory.
  assign mem_wr.en   = s1_valid_r && s2_ready;
  assign mem_wr.addr = s1_r.wp;
  assign mem_wr.data = y;

  fce_delay_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (past)
  );

  fce_echo_arith u_arith (
    .sample   (s1_r.sample),
    .past     (past),
    .use_echo (s1_r.use_echo),
    .y        (y)
  );

  fce_gain_stage u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .y_valid    (s1_valid_r),
    .y_ready    (s2_ready),
    .y          (y),
    .gain       (cfg_gain_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `FCE_ASSERT(a_fill_bound, fill_r <= CNT_W'(MAX_DELAY), "fill count above line depth")
  `FCE_ASSERT(a_wp_bound, wp_r <= ADDR_W'(MAX_DELAY - 1), "write pointer outside the line")
  `FCE_ASSERT(a_restart_fill, in_fire && in_tuser |=> fill_r == CNT_W'(1), "restart did not reset history")
  `FCE_ASSERT(a_fire_loads, in_fire |=> s1_valid_r, "accepted sample lost before the mix stage")
  `FCE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !s1_valid_r && !out_tvalid, "pipeline not empty after reset")

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Feedback comb echo regression bench
// Drives audio samples into the echo block over the input stream and checks
// every result against a cycle-free predictor that tracks its own copy of
// the history, fill count and register settings. The bench has directed
// cases for saturation, truncation, restarts and delay clamping, then random
// phases at short and full-length delays, with random sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import fce_pkg::*;

  // Pipeline depth from input transaction to output transaction when unstalled.
  localparam int LATENCY = 3;
  // Cycles without any transaction before the run is declared hung. Real
  // quiet stretches are config writes, drains and short gaps, all far below.
  localparam int HANG_LIMIT = 2000;

  // One result transaction, laid out as out_tdata: echo in the low half.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] played;
    logic signed [SAMPLE_W-1:0] echo;
  } echo_pair_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // [15:0] sample_in
  logic                  in_tuser = 1'b0;  // [0] restart
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [15:0] echo_sample, [31:16] played_sample
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Receiver behavior: when stalls are enabled, ready alternates between runs
  // of random length; otherwise the receiver takes every result at once.
  bit rx_stall_en = 1'b0;

  // Expected results, oldest first, and the failure tally.
  echo_pair_t echo_q[$];
  int         mismatch_count = 0;
  int         quiet_cycles = 0;

  // Predictor state: mirrors the block's registers and echo history.
  logic [DELAY_W-1:0]         pred_delay;
  logic [GAIN_W-1:0]          pred_gain;
  logic signed [SAMPLE_W-1:0] pred_hist [MAX_DELAY];
  logic [ADDR_W-1:0]          pred_wr_ptr;
  logic [CNT_W-1:0]           pred_fill;

  feedback_comb_echo DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Clamp a wide intermediate to the signed 16-bit range.
  function automatic logic signed [SAMPLE_W-1:0] clip16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return SAMPLE_W'(v);
  endfunction

  // Runs one sample through the echo recursion and advances the history.
  function automatic echo_pair_t predict_echo(input logic signed [SAMPLE_W-1:0] sample,
                                              input logic restart);
    int          eff_delay;
    int          past;
    int          echo_term;
    echo_pair_t  res;
    // A delay of zero acts as one; anything past the line length acts as
    // the full line.
    eff_delay = int'(pred_delay);
    if (eff_delay < 1) eff_delay = 1;
    if (eff_delay > MAX_DELAY) eff_delay = MAX_DELAY;
    // A restart clears the history count before this sample is mixed, so the
    // sample itself already gets no echo.
    if (restart) pred_fill = '0;
    echo_term = 0;
    // The echo term is used only once the history since the last restart
    // reaches back far enough; that entry is then known to be written.
    if (int'(pred_fill) >= eff_delay) begin
      past = int'(pred_hist[ADDR_W'(pred_wr_ptr - ADDR_W'(eff_delay))]);
      // SystemVerilog integer division truncates toward zero, as required.
      echo_term = (2 * past) / 3;
    end
    res.echo = clip16(int'(sample) + echo_term);
    res.played = clip16(int'(res.echo) * int'(pred_gain));
    pred_hist[pred_wr_ptr] = res.echo;
    pred_wr_ptr = pred_wr_ptr + ADDR_W'(1);
    if (int'(pred_fill) < MAX_DELAY) pred_fill = pred_fill + CNT_W'(1);
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge, so the values seen
  // are the ones the block itself saw. Outputs are matched before the input
  // of the same edge is predicted; as every input passes the pipeline registers
  // first, an output can never belong to an input accepted at that same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    echo_pair_t got;
    echo_pair_t want;
    if (!rst_n) begin
      pred_delay  = DELAY_RESET;
      pred_gain   = GAIN_RESET;
      pred_wr_ptr = '0;
      pred_fill   = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_e'(cfg_addr))
          CFG_DELAY: pred_delay = cfg_wdata[DELAY_W-1:0];
          CFG_GAIN:  pred_gain = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (echo_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result echo=%0d played=%0d",
                                 got.echo, got.played));
        end else begin
          want = echo_q.pop_front();
          if (got.echo !== want.echo || got.played !== want.played) begin
            log_mismatch($sformatf("mismatch: expected echo=%0d played=%0d, got echo=%0d played=%0d",
                                   want.echo, want.played, got.echo, got.played));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        echo_q.push_back(predict_echo(in_tdata, in_tuser));
      end
    end
  end

  // Receiver stall pattern: ready runs alternate with stall runs, both of random
  // length, so stalls land on every stage of the pipeline.
  always @(posedge clk) begin : rx_pattern
    bit rx_ready_phase;
    int rx_run;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_ready_phase = 1'b0;
      rx_run = 0;
    end else if (!rx_stall_en) begin
      out_tready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_ready_phase = !rx_ready_phase;
        rx_run = rx_ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 5);
      end
      rx_run--;
      out_tready <= rx_ready_phase;
    end
  end

  // Hang detection: any transaction on either stream restarts the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers. All of them are entered and left at a rising edge.
  // --------------------------------------------------------------------------

  // Presents one sample and returns at the edge that accepts it, with valid
  // still high so the next sample of a burst can follow without a bubble.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample, input logic restart);
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drops valid and stays quiet for the given number of cycles (at least one).
  task automatic hold_input(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until every expected result has come back, plus the pipeline depth.
  task automatic wait_idle();
    while (echo_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Register write; only called while no transaction is in flight.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random audio: mostly full-range values, some near zero where the
  // truncation of negative echoes matters, some near either rail.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return SAMPLE_W'($urandom);
    if (sel < 8) return SAMPLE_W'(int'($urandom_range(0, 127)) - 64);
    if (sel == 8) return SAMPLE_W'(32767 - int'($urandom_range(0, 3)));
    return SAMPLE_W'(-32768 + int'($urandom_range(0, 3)));
  endfunction

  // Streams random samples in bursts of 1..20. With gaps enabled, each burst
  // is followed by a random idle gap; otherwise the stream runs back to back.
  // restart_odds of N sets a restart about once per N samples (0 = never).
  task automatic play_random(input int count, input int restart_odds,
                             input bit first_restart, input bit gaps);
    int  burst_left;
    bit  restart;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) burst_left = $urandom_range(1, 20);
      restart = (i == 0 && first_restart) ||
                (restart_odds > 0 && $urandom_range(0, restart_odds - 1) == 0);
      send_sample(pick_sample(), restart);
      burst_left--;
      if (burst_left == 0 && gaps) hold_input($urandom_range(1, 6));
    end
    hold_input(1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings (delay 560, gain 10): no echo yet, so the playback copy
  // shows the gain and its saturation at both rails.
  task automatic test_reset_defaults();
    rx_stall_en <= 1'b0;
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd3277, 1'b0);
    send_sample(-16'sd3277, 1'b0);
    send_sample(16'sd3276, 1'b0);
    hold_input(1);
    wait_idle();
  endtask

  // One-sample delay at full gain: the sum saturates at both rails, small
  // negative echoes truncate toward zero, and a restart drops the history.
  task automatic test_saturation_short_delay();
    write_reg(CFG_DELAY, 11'd1);
    write_reg(CFG_GAIN, 11'd15);
    rx_stall_en <= 1'b1;
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd2, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    hold_input(1);
    wait_idle();
  endtask

  // Delay register at zero, above the line length and exactly at it; gain at
  // zero mutes the playback copy.
  task automatic test_delay_clamping();
    write_reg(CFG_DELAY, 11'd0);
    write_reg(CFG_GAIN, 11'd0);
    send_sample(16'sd100, 1'b1);
    send_sample(16'sd100, 1'b0);
    hold_input(1);
    wait_idle();
    write_reg(CFG_DELAY, 11'd2047);
    write_reg(CFG_GAIN, 11'd1);
    send_sample(16'sd5, 1'b1);
    send_sample(-16'sd5, 1'b0);
    hold_input(1);
    wait_idle();
    write_reg(CFG_DELAY, 11'd1024);
    send_sample(16'sd7, 1'b1);
    hold_input(1);
    wait_idle();
  endtask

  // Short delays with frequent echoes. Rounds do not restart at their start,
  // so a new delay longer than the current history exercises the guard.
  task automatic test_random_short_delays();
    logic [CFG_DATA_W-1:0] delay_val;
    for (int round = 0; round < 4; round++) begin
      case (round)
        0: delay_val = 11'd1;
        1: delay_val = 11'd2;
        default: delay_val = CFG_DATA_W'($urandom_range(3, 40));
      endcase
      write_reg(CFG_DELAY, delay_val);
      write_reg(CFG_GAIN, (round == 0) ? 11'd15 :
                          (round == 1) ? 11'd0 : CFG_DATA_W'($urandom_range(0, 15)));
      rx_stall_en <= round[0];
      play_random(40, 30, 1'b0, !round[1]);
      wait_idle();
    end
  endtask

  // Full-length history: after a restart the line fills completely and the
  // echo reaches back the whole line. Halfway, the sender holds off until
  // everything has drained and the gain is changed.
  task automatic test_random_full_history();
    write_reg(CFG_DELAY, 11'd2047);
    write_reg(CFG_GAIN, CFG_DATA_W'($urandom_range(1, 15)));
    rx_stall_en <= 1'b1;
    play_random(520, 0, 1'b1, 1'b1);
    wait_idle();
    write_reg(CFG_GAIN, CFG_DATA_W'($urandom_range(0, 15)));
    play_random(540, 0, 1'b0, 1'b1);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_saturation_short_delay();
    test_delay_clamping();
    test_random_short_delays();
    test_random_full_history();

    repeat (LATENCY + 5) @(posedge clk);
    // Anything still waiting here never came back.
    mismatch_count += echo_q.size();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
